// ===== src/quad_interval_timer_peripheral_assert.svh =====
// Assertion macros shared by the timer block.
// Each macro expands to one labeled concurrent assertion, or to nothing when SYNTH is set.
`ifndef QUAD_INTERVAL_TIMER_PERIPHERAL_ASSERT_SVH
`define QUAD_INTERVAL_TIMER_PERIPHERAL_ASSERT_SVH

`ifndef SYNTH

`define QITP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle property failed");

`define QITP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle property failed");

`else

`define QITP_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define QITP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/qitp_pkg.sv =====
package qitp_pkg;

    localparam int NUM_TIMERS = 4;

    // Commands carried in the input tuser.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // Register map offsets.
    localparam logic [3:0] REG_CTRL0     = 4'd0;
    localparam logic [3:0] REG_CTRL1     = 4'd1;
    localparam logic [3:0] REG_CTRL2     = 4'd2;
    localparam logic [3:0] REG_CTRL3     = 4'd3;
    localparam logic [3:0] REG_CTRL4     = 4'd4;
    localparam logic [3:0] REG_INT       = 4'd5;
    localparam logic [3:0] REG_SELECT    = 4'd6;
    localparam logic [3:0] REG_WATCHDOG  = 4'd7;
    localparam logic [3:0] REG_RELOAD_LO = 4'd8;
    localparam logic [3:0] REG_RELOAD_HI = 4'd9;
    localparam logic [3:0] REG_PRESC_LO  = 4'd10;
    localparam logic [3:0] REG_PRESC_HI  = 4'd11;

    // Control bit masks.
    localparam logic [7:0] BIT_SOFT_RESET  = 8'h01;
    localparam logic [7:0] BIT_ACTIVE      = 8'h02;
    localparam logic [7:0] BIT_LATCH_PRESC = 8'h10;
    localparam logic [7:0] MASK_FIRED      = 8'h55;
    localparam logic [7:0] MASK_ENABLE     = 8'hAA;

    typedef logic [15:0] count_t;

    typedef struct packed {
        logic       irq;
        logic [7:0] read_data;
    } result_t;

endpackage

// ===== src/quad_interval_timer_peripheral.sv =====
// Quad interval timer peripheral.
//
// The input stream carries one item per transfer: s_tuser holds the command
// (tick, register read or register write) and s_tdata holds the register
// offset and the write byte. Every accepted item yields exactly one result
// transfer on the output stream, carrying the read byte and the irq flag.
//
// All work for an item is done in the cycle it is accepted: the timer state
// updates at that clock edge and the result lands in the output register, or
// in the skid register while the receiver stalls. The block accepts one item
// per cycle while the skid register is empty; the state update path
// (prescaler compare plus one 16-bit compare and increment per timer) is combinational.
//
// The output side has a register and a skid register. While the receiver
// stalls, one further item is still accepted into the skid stage; after that
// s_tready drops until the receiver takes a transfer again.
//
// Reset (rst_n low, asynchronous) clears every control byte, reload value,
// counter, running flag and the prescaler, and empties both output stages.
// A soft-reset write to control0 clears the same state, but control0 takes the written byte.
module quad_interval_timer_peripheral
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [3:0] reg_index, [11:4] write_data, [15:12] zero
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [7:0] read_data, [8] irq, [15:9] zero
);

    // Register file and timer state.
    logic [7:0] ctrl0_reg, ctrl0_next;
    logic [7:0] ctrl1_reg, ctrl1_next;
    logic [7:0] ctrl2_reg, ctrl2_next;
    logic [7:0] ctrl3_reg, ctrl3_next;
    logic [7:0] ctrl4_reg, ctrl4_next;
    logic [7:0] int_reg, int_next;
    logic [7:0] select_reg, select_next;
    logic [7:0] wdog_reg, wdog_next;
    logic [7:0] presc_lo_reg, presc_lo_next;
    logic [7:0] presc_hi_reg, presc_hi_next;

    qitp_pkg::count_t reload_reg [qitp_pkg::NUM_TIMERS];
    qitp_pkg::count_t reload_next [qitp_pkg::NUM_TIMERS];
    qitp_pkg::count_t count_reg [qitp_pkg::NUM_TIMERS];
    qitp_pkg::count_t count_next [qitp_pkg::NUM_TIMERS];
    logic [qitp_pkg::NUM_TIMERS-1:0] running_reg, running_next;

    qitp_pkg::count_t pdiv_reg, pdiv_next;
    qitp_pkg::count_t pcount_reg, pcount_next;

    // Output register and skid register.
    logic               out_valid_reg, out_valid_next;
    qitp_pkg::result_t  out_data_reg, out_data_next;
    logic               skid_valid_reg, skid_valid_next;
    qitp_pkg::result_t  skid_data_reg, skid_data_next;

    logic              accept;
    logic              drain;
    logic [1:0]        command;
    logic [3:0]        reg_index;
    logic [7:0]        write_data;
    qitp_pkg::result_t result;

    assign command    = s_tuser;
    assign reg_index  = s_tdata[3:0];
    assign write_data = s_tdata[11:4];

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign drain    = out_valid_reg && m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_data_reg};

    // Item processing: the state update and the result of the accepted item.
    always_comb
    begin
        logic scaled;
        logic use_scaled;

        ctrl0_next    = ctrl0_reg;
        ctrl1_next    = ctrl1_reg;
        ctrl2_next    = ctrl2_reg;
        ctrl3_next    = ctrl3_reg;
        ctrl4_next    = ctrl4_reg;
        int_next      = int_reg;
        select_next   = select_reg;
        wdog_next     = wdog_reg;
        presc_lo_next = presc_lo_reg;
        presc_hi_next = presc_hi_reg;
        reload_next   = reload_reg;
        count_next    = count_reg;
        running_next  = running_reg;
        pdiv_next     = pdiv_reg;
        pcount_next   = pcount_reg;
        result        = '0;
        scaled        = 1'b0;
        use_scaled    = 1'b0;

        if (accept)
        begin
            case (command)
                qitp_pkg::CMD_TICK:
                begin
                    if ((ctrl0_reg & qitp_pkg::BIT_ACTIVE) != 8'd0)
                    begin
                        scaled = (pcount_reg == pdiv_reg);
                        pcount_next = scaled ? 16'd0 : pcount_reg + 16'd1;
                        for (int t = 0; t < qitp_pkg::NUM_TIMERS; t++)
                        begin
                            use_scaled = ctrl2_reg[4 + t];
                            if (running_reg[t] && (!use_scaled || scaled))
                            begin
                                if (count_reg[t] >= reload_reg[t])
                                begin
                                    count_next[t] = 16'd0;
                                    if (int_reg[2 * t + 1])
                                    begin
                                        int_next[2 * t] = 1'b1;
                                        result.irq      = 1'b1;
                                    end
                                    if (ctrl3_reg[t])
                                    begin
                                        running_next[t] = 1'b0;
                                    end
                                end
                                else
                                begin
                                    count_next[t] = count_reg[t] + 16'd1;
                                end
                            end
                        end
                    end
                end

                qitp_pkg::CMD_READ:
                begin
                    unique case (reg_index)
                        qitp_pkg::REG_CTRL0:    result.read_data = ctrl0_reg;
                        qitp_pkg::REG_CTRL1:    result.read_data = ctrl1_reg;
                        qitp_pkg::REG_CTRL2:    result.read_data = ctrl2_reg;
                        qitp_pkg::REG_CTRL3:    result.read_data = ctrl3_reg;
                        qitp_pkg::REG_CTRL4:    result.read_data = ctrl4_reg;
                        qitp_pkg::REG_INT:      result.read_data = int_reg;
                        qitp_pkg::REG_SELECT:   result.read_data = select_reg;
                        qitp_pkg::REG_WATCHDOG: result.read_data = wdog_reg;
                        qitp_pkg::REG_PRESC_LO: result.read_data = presc_lo_reg;
                        qitp_pkg::REG_PRESC_HI: result.read_data = presc_hi_reg;
                        default:                result.read_data = 8'd0;
                    endcase
                end

                qitp_pkg::CMD_WRITE:
                begin
                    unique case (reg_index)
                        qitp_pkg::REG_CTRL0:
                        begin
                            // Soft reset clears all timer state before the byte is stored.
                            if ((write_data & qitp_pkg::BIT_SOFT_RESET) != 8'd0)
                            begin
                                ctrl1_next    = 8'd0;
                                ctrl2_next    = 8'd0;
                                ctrl3_next    = 8'd0;
                                ctrl4_next    = 8'd0;
                                int_next      = 8'd0;
                                select_next   = 8'd0;
                                wdog_next     = 8'd0;
                                presc_lo_next = 8'd0;
                                presc_hi_next = 8'd0;
                                running_next  = '0;
                                pdiv_next     = 16'd0;
                                pcount_next   = 16'd0;
                                for (int t = 0; t < qitp_pkg::NUM_TIMERS; t++)
                                begin
                                    reload_next[t] = 16'd0;
                                    count_next[t]  = 16'd0;
                                end
                            end
                            ctrl0_next = write_data;
                        end
                        qitp_pkg::REG_CTRL1:
                        begin
                            // Start wins over stop for the same timer.
                            for (int t = 0; t < qitp_pkg::NUM_TIMERS; t++)
                            begin
                                if (write_data[t])
                                    running_next[t] = 1'b1;
                                else if (write_data[4 + t])
                                    running_next[t] = 1'b0;
                            end
                            ctrl1_next = write_data;
                        end
                        qitp_pkg::REG_CTRL2:    ctrl2_next = write_data;
                        qitp_pkg::REG_CTRL3:    ctrl3_next = write_data;
                        qitp_pkg::REG_CTRL4:
                        begin
                            for (int t = 0; t < qitp_pkg::NUM_TIMERS; t++)
                            begin
                                if (write_data[t])
                                    count_next[t] = 16'd0;
                            end
                            if ((write_data & qitp_pkg::BIT_LATCH_PRESC) != 8'd0)
                            begin
                                pdiv_next   = {presc_hi_reg, presc_lo_reg};
                                pcount_next = 16'd0;
                            end
                            ctrl4_next = write_data & ~qitp_pkg::BIT_LATCH_PRESC;
                        end
                        qitp_pkg::REG_INT:
                        begin
                            // Fired bits are write-one-to-clear, enable bits follow the data.
                            int_next = (int_reg & qitp_pkg::MASK_FIRED
                                        & ~(write_data & qitp_pkg::MASK_FIRED))
                                       | (write_data & qitp_pkg::MASK_ENABLE);
                        end
                        qitp_pkg::REG_SELECT:   select_next = write_data;
                        qitp_pkg::REG_WATCHDOG: wdog_next   = write_data;
                        qitp_pkg::REG_RELOAD_LO:
                        begin
                            for (int t = 0; t < qitp_pkg::NUM_TIMERS; t++)
                            begin
                                if (select_reg == 8'(t))
                                    reload_next[t] = {reload_reg[t][15:8], write_data};
                            end
                        end
                        qitp_pkg::REG_RELOAD_HI:
                        begin
                            for (int t = 0; t < qitp_pkg::NUM_TIMERS; t++)
                            begin
                                if (select_reg == 8'(t))
                                    reload_next[t] = {write_data, reload_reg[t][7:0]};
                            end
                        end
                        qitp_pkg::REG_PRESC_LO: presc_lo_next = write_data;
                        qitp_pkg::REG_PRESC_HI: presc_hi_next = write_data;
                        // The value registers and the undefined offsets keep nothing readable.
                        default:
                        begin
                        end
                    endcase
                end

                default:
                begin
                end
            endcase
        end
    end

    // Output register with a skid stage behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (skid_valid_reg && drain)
        begin
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        else if (accept)
        begin
            if (!out_valid_reg || drain)
            begin
                out_valid_next = 1'b1;
                out_data_next  = result;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = result;
            end
        end
        else if (drain)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl0_reg      <= 8'd0;
            ctrl1_reg      <= 8'd0;
            ctrl2_reg      <= 8'd0;
            ctrl3_reg      <= 8'd0;
            ctrl4_reg      <= 8'd0;
            int_reg        <= 8'd0;
            select_reg     <= 8'd0;
            wdog_reg       <= 8'd0;
            presc_lo_reg   <= 8'd0;
            presc_hi_reg   <= 8'd0;
            running_reg    <= '0;
            pdiv_reg       <= 16'd0;
            pcount_reg     <= 16'd0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            for (int t = 0; t < qitp_pkg::NUM_TIMERS; t++)
            begin
                reload_reg[t] <= 16'd0;
                count_reg[t]  <= 16'd0;
            end
        end
        else
        begin
            ctrl0_reg      <= ctrl0_next;
            ctrl1_reg      <= ctrl1_next;
            ctrl2_reg      <= ctrl2_next;
            ctrl3_reg      <= ctrl3_next;
            ctrl4_reg      <= ctrl4_next;
            int_reg        <= int_next;
            select_reg     <= select_next;
            wdog_reg       <= wdog_next;
            presc_lo_reg   <= presc_lo_next;
            presc_hi_reg   <= presc_hi_next;
            running_reg    <= running_next;
            pdiv_reg       <= pdiv_next;
            pcount_reg     <= pcount_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            reload_reg     <= reload_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

`include "quad_interval_timer_peripheral_assert.svh"

    // The skid stage only fills behind a full output register.
    `QITP_ASSERT_SAME(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)

    // A transfer taken while the receiver stalls a full output register goes to the skid stage.
    `QITP_ASSERT_NEXT(a_stall_fills_skid, clk, rst_n,
        accept && out_valid_reg && !m_tready, skid_valid_reg)

    // The prescaler counter never passes its divisor.
    `QITP_ASSERT_SAME(a_presc_bound, clk, rst_n, 1'b1, pcount_reg <= pdiv_reg)

    // A soft reset stops every timer and clears the prescaler.
    `QITP_ASSERT_NEXT(a_soft_reset, clk, rst_n,
        accept && command == qitp_pkg::CMD_WRITE && reg_index == qitp_pkg::REG_CTRL0
            && write_data[0],
        running_reg == '0 && pdiv_reg == 16'd0 && pcount_reg == 16'd0)

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    // Codes and offsets that the package leaves unnamed.
    localparam logic [1:0] CMD_NONE     = 2'd3;
    localparam logic [3:0] REG_VALUE_LO = 4'd12;
    localparam logic [3:0] REG_VALUE_HI = 4'd13;
    localparam logic [3:0] REG_SPARE_LO = 4'd14;
    localparam logic [3:0] REG_SPARE_HI = 4'd15;

    localparam int CLK_HIGH     = 6;
    localparam int CLK_LOW      = 6;
    localparam int RANDOM_ITEMS = 1750;
    localparam int PHASE_ITEMS  = 300;
    localparam int DRAIN_LIMIT  = 20000;

    // Holds the timer state as the block should see it and the results it owes.
    class timer_scoreboard;
        logic [7:0]          reg_bytes [16];
        qitp_pkg::count_t    reload [qitp_pkg::NUM_TIMERS];
        qitp_pkg::count_t    counts [qitp_pkg::NUM_TIMERS];
        logic                running [qitp_pkg::NUM_TIMERS];
        qitp_pkg::count_t    presc_div;
        qitp_pkg::count_t    presc_cnt;
        qitp_pkg::result_t   owed_results [$];
        int                  errors;

        function new();
            errors = 0;
            clear_timers();
        endfunction

        function void clear_timers();
            int i;
            for (i = 0; i < 16; i++)
                reg_bytes[i] = 8'h00;
            for (i = 0; i < qitp_pkg::NUM_TIMERS; i++)
            begin
                reload[i]  = '0;
                counts[i]  = '0;
                running[i] = 1'b0;
            end
            presc_div = '0;
            presc_cnt = '0;
        endfunction

        function logic predict_tick();
            logic fired_irq;
            logic scaled;
            int   t;
            fired_irq = 1'b0;
            if ((reg_bytes[qitp_pkg::REG_CTRL0] & qitp_pkg::BIT_ACTIVE) == 8'h00)
                return 1'b0;
            scaled = (presc_cnt == presc_div);
            presc_cnt = scaled ? qitp_pkg::count_t'(0) : qitp_pkg::count_t'(presc_cnt + 1);
            for (t = 0; t < qitp_pkg::NUM_TIMERS; t++)
            begin
                // A prescaled timer only moves on the prescaler's wrap tick.
                if (running[t] && (scaled || !reg_bytes[qitp_pkg::REG_CTRL2][4 + t]))
                begin
                    if (counts[t] >= reload[t])
                    begin
                        counts[t] = '0;
                        if (reg_bytes[qitp_pkg::REG_INT][2 * t + 1])
                        begin
                            reg_bytes[qitp_pkg::REG_INT][2 * t] = 1'b1;
                            fired_irq = 1'b1;
                        end
                        if (reg_bytes[qitp_pkg::REG_CTRL3][t])
                            running[t] = 1'b0;
                    end
                    else
                    begin
                        counts[t] = counts[t] + 1'b1;
                    end
                end
            end
            return fired_irq;
        endfunction

        function void apply_write(logic [3:0] idx, logic [7:0] data);
            logic [7:0] sel;
            int         t;
            sel = reg_bytes[qitp_pkg::REG_SELECT];
            case (idx)
                qitp_pkg::REG_CTRL0:
                begin
                    if ((data & qitp_pkg::BIT_SOFT_RESET) != 8'h00)
                        clear_timers();
                    reg_bytes[qitp_pkg::REG_CTRL0] = data;
                end
                qitp_pkg::REG_CTRL1:
                begin
                    // Start wins over stop for the same timer.
                    for (t = 0; t < qitp_pkg::NUM_TIMERS; t++)
                    begin
                        if (data[t])
                            running[t] = 1'b1;
                        else if (data[4 + t])
                            running[t] = 1'b0;
                    end
                    reg_bytes[qitp_pkg::REG_CTRL1] = data;
                end
                qitp_pkg::REG_CTRL4:
                begin
                    for (t = 0; t < qitp_pkg::NUM_TIMERS; t++)
                        if (data[t])
                            counts[t] = '0;
                    if ((data & qitp_pkg::BIT_LATCH_PRESC) != 8'h00)
                    begin
                        presc_div = {reg_bytes[qitp_pkg::REG_PRESC_HI],
                                     reg_bytes[qitp_pkg::REG_PRESC_LO]};
                        presc_cnt = '0;
                    end
                    reg_bytes[qitp_pkg::REG_CTRL4] = data & ~qitp_pkg::BIT_LATCH_PRESC;
                end
                qitp_pkg::REG_INT:
                begin
                    // Fired bits clear on a written one; enables follow the data.
                    reg_bytes[qitp_pkg::REG_INT] =
                        (reg_bytes[qitp_pkg::REG_INT] & qitp_pkg::MASK_FIRED
                         & ~(data & qitp_pkg::MASK_FIRED))
                        | (data & qitp_pkg::MASK_ENABLE);
                end
                qitp_pkg::REG_RELOAD_LO:
                begin
                    if (sel < qitp_pkg::NUM_TIMERS)
                        reload[sel[1:0]][7:0] = data;
                end
                qitp_pkg::REG_RELOAD_HI:
                begin
                    if (sel < qitp_pkg::NUM_TIMERS)
                        reload[sel[1:0]][15:8] = data;
                end
                default:
                begin
                    if (idx <= REG_VALUE_HI)
                        reg_bytes[idx] = data;
                end
            endcase
        endfunction

        function void note_item(logic [1:0] cmd, logic [3:0] idx, logic [7:0] data);
            qitp_pkg::result_t res;
            res = '0;
            case (cmd)
                qitp_pkg::CMD_TICK:
                    res.irq = predict_tick();
                qitp_pkg::CMD_READ:
                begin
                    // Reload, value and spare offsets always read back as zero.
                    if (idx < qitp_pkg::REG_RELOAD_LO || idx == qitp_pkg::REG_PRESC_LO
                        || idx == qitp_pkg::REG_PRESC_HI)
                        res.read_data = reg_bytes[idx];
                end
                qitp_pkg::CMD_WRITE:
                    apply_write(idx, data);
                default:
                    ;
            endcase
            owed_results.push_back(res);
        endfunction

        function void check_result(logic [15:0] beat);
            qitp_pkg::result_t want;
            if (owed_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual read_data %h irq %b",
                         $time, beat[7:0], beat[8]);
                return;
            end
            want = owed_results.pop_front();
            if (beat[7:0] !== want.read_data)
            begin
                errors++;
                $display("%0t: read_data expected %h actual %h", $time, want.read_data, beat[7:0]);
            end
            if (beat[8] !== want.irq)
            begin
                errors++;
                $display("%0t: irq expected %b actual %b", $time, want.irq, beat[8]);
            end
            if (beat[15:9] !== 7'h00)
            begin
                errors++;
                $display("%0t: padding expected %h actual %h", $time, 7'h00, beat[15:9]);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    timer_scoreboard sb;
    int              items_sent;
    int              src_idle_pct;
    int              sink_stall_pct;

    quad_interval_timer_peripheral u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #(CLK_LOW);
        clk = 1'b1;
        #(CLK_HIGH);
    end

    // Receiver side: stall at random, check every transfer at the rising edge.
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);

    // Presents one item, waits for its transfer and records what it should cause.
    // Called and returning at a falling edge.
    task automatic send_item(input logic [1:0] cmd, input logic [3:0] idx, input logic [7:0] data);
        int phase;
        phase = (items_sent / PHASE_ITEMS) % 4;
        case (phase)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 77; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 77; end
            default: begin src_idle_pct = 30; sink_stall_pct = 30; end
        endcase
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 16'($urandom);
            s_tuser  <= 2'($urandom);
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'h0, data, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_item(cmd, idx, data);
        if (!(cmd == CMD_NONE || (cmd == qitp_pkg::CMD_WRITE && idx > REG_VALUE_HI)))
            items_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [7:0] data);
        send_item(qitp_pkg::CMD_WRITE, idx, data);
    endtask

    task automatic read_reg(input logic [3:0] idx);
        send_item(qitp_pkg::CMD_READ, idx, 8'($urandom));
    endtask

    task automatic tick_run(input int n);
        repeat (n) send_item(qitp_pkg::CMD_TICK, 4'($urandom), 8'($urandom));
    endtask

    // Mostly small so that timers fire often; now and then any byte.
    function automatic logic [7:0] pick_small(input int hi);
        if ($urandom_range(99) < 10)
            return 8'($urandom_range(255));
        return 8'($urandom_range(hi));
    endfunction

    initial
    begin
        #(5_000_000);
        $display("quad_interval_timer_peripheral: mismatch");
        $finish;
    end

    initial
    begin
        int t;
        int n;
        int run_len;
        int roll;
        int drain_cycles;
        logic [7:0] start_byte;

        sb = new();
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = 16'h0000;
        s_tuser        = qitp_pkg::CMD_TICK;
        items_sent     = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: address decode corners, then one-shot firing of timer 0.
        write_reg(qitp_pkg::REG_SELECT, 8'h00);
        write_reg(qitp_pkg::REG_RELOAD_LO, 8'h02);
        write_reg(qitp_pkg::REG_RELOAD_HI, 8'h00);
        write_reg(qitp_pkg::REG_SELECT, 8'hFF);          // out of range, reload writes dropped
        write_reg(qitp_pkg::REG_RELOAD_LO, 8'hFF);
        read_reg(qitp_pkg::REG_RELOAD_LO);
        write_reg(REG_VALUE_LO, 8'h5A);
        read_reg(REG_VALUE_LO);
        write_reg(REG_VALUE_HI, 8'hFF);
        read_reg(REG_VALUE_HI);
        write_reg(REG_SPARE_LO, 8'hFF);
        read_reg(REG_SPARE_HI);
        send_item(CMD_NONE, qitp_pkg::REG_CTRL0, 8'hFF);
        write_reg(qitp_pkg::REG_INT, 8'hFF);
        write_reg(qitp_pkg::REG_CTRL3, 8'hF1);           // timer 0 one-shot, direction bits stored
        write_reg(qitp_pkg::REG_CTRL1, 8'h11);           // start and stop together
        write_reg(qitp_pkg::REG_CTRL0, 8'hFE);           // active plus unused bits, no soft reset
        tick_run(4);
        read_reg(qitp_pkg::REG_INT);
        write_reg(qitp_pkg::REG_INT, 8'h01);
        write_reg(qitp_pkg::REG_PRESC_LO, 8'hFF);
        write_reg(qitp_pkg::REG_PRESC_HI, 8'hFF);
        write_reg(qitp_pkg::REG_CTRL4, 8'hFF);
        read_reg(qitp_pkg::REG_CTRL4);
        write_reg(qitp_pkg::REG_CTRL0, 8'h01);           // soft reset
        read_reg(qitp_pkg::REG_CTRL0);

        // Random part: mostly full timer setups followed by ticking, with noise bursts.
        while (items_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(99) < 85)
            begin
                if ($urandom_range(99) < 20)
                    write_reg(qitp_pkg::REG_CTRL0,
                              8'($urandom_range(255)) | qitp_pkg::BIT_SOFT_RESET);
                for (t = 0; t < qitp_pkg::NUM_TIMERS; t++)
                begin
                    if ($urandom_range(99) < 70)
                    begin
                        write_reg(qitp_pkg::REG_SELECT, 8'(t));
                        write_reg(qitp_pkg::REG_RELOAD_LO, pick_small(6));
                        write_reg(qitp_pkg::REG_RELOAD_HI, pick_small(0));
                    end
                end
                if ($urandom_range(99) < 15)
                begin
                    write_reg(qitp_pkg::REG_SELECT,
                              8'($urandom_range(255, qitp_pkg::NUM_TIMERS)));
                    write_reg(4'(qitp_pkg::REG_RELOAD_LO + $urandom_range(1)),
                              8'($urandom_range(255)));
                end
                write_reg(qitp_pkg::REG_PRESC_LO, pick_small(3));
                write_reg(qitp_pkg::REG_PRESC_HI, pick_small(0));
                write_reg(qitp_pkg::REG_CTRL4,
                          8'($urandom_range(255)) | qitp_pkg::BIT_LATCH_PRESC);
                write_reg(qitp_pkg::REG_CTRL2, 8'($urandom_range(255)));
                write_reg(qitp_pkg::REG_CTRL3, 8'($urandom_range(255)));
                write_reg(qitp_pkg::REG_INT, 8'($urandom_range(255)));
                write_reg(qitp_pkg::REG_CTRL0,
                          (8'($urandom_range(255)) | qitp_pkg::BIT_ACTIVE)
                          & ~qitp_pkg::BIT_SOFT_RESET);
                start_byte = 8'($urandom_range(255));
                if ($urandom_range(1) == 0)
                    start_byte = start_byte | 8'h0F;
                write_reg(qitp_pkg::REG_CTRL1, start_byte);
                run_len = $urandom_range(80, 20);
                for (n = 0; n < run_len; n++)
                begin
                    roll = $urandom_range(99);
                    if (roll < 74)
                        tick_run(1);
                    else if (roll < 86)
                        read_reg(4'($urandom_range(15)));
                    else if (roll < 93)
                        write_reg(qitp_pkg::REG_INT, 8'($urandom_range(255)));
                    else if (roll < 96)
                        write_reg(qitp_pkg::REG_CTRL1, 8'($urandom_range(255)));
                    else if (roll < 98)
                        write_reg(qitp_pkg::REG_CTRL4, 8'($urandom_range(255)));
                    else
                        write_reg(qitp_pkg::REG_CTRL0,
                                  8'($urandom_range(255)) & ~qitp_pkg::BIT_SOFT_RESET);
                end
            end
            else
            begin
                repeat ($urandom_range(15, 5))
                    send_item(2'($urandom_range(3)), 4'($urandom_range(15)),
                              8'($urandom_range(255)));
            end
        end
        s_tvalid <= 1'b0;

        // Let the output stages empty, then give stray transfers a chance to show up.
        drain_cycles = 0;
        while (sb.owed_results.size() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (8) @(posedge clk);
        if (sb.owed_results.size() != 0)
        begin
            sb.errors++;
            $display("%0t: results outstanding at end, expected read_data %h irq %b, actual none",
                     $time, sb.owed_results[0].read_data, sb.owed_results[0].irq);
        end
        if (sb.errors == 0)
            $display("quad_interval_timer_peripheral: match");
        else
            $display("quad_interval_timer_peripheral: mismatch");
        $finish;
    end

endmodule
